FILE: sv/ic8259_pkg.sv
// Shared types, command bit constants and helper functions for the 8259 core.
// Used by ic8259_engine and interrupt_controller_8259_core; no dependencies.
`default_nettype none

package ic8259_pkg;

  // Kind of bus or interrupt event carried by one input item
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_RAISE = 2'd2,
    ACT_ACK   = 2'd3
  } action_e;

  // Command byte decode bits
  localparam logic [7:0] CMD_ICW1      = 8'h10;
  localparam logic [7:0] CMD_OCW3      = 8'h08;
  localparam logic [7:0] CMD_EOI       = 8'h20;
  localparam logic [7:0] OCW3_RR       = 8'h02;
  localparam logic [7:0] RSEL_ISR      = 8'h01;
  localparam logic [7:0] INIT_ICW4_REQ = 8'h01;
  localparam logic [7:0] INIT_SINGLE   = 8'h02;
  localparam logic [7:0] ICW2_BASE     = 8'hf8;
  localparam logic [7:0] IMR_RESET     = 8'hff;

  // Pending init word flags
  localparam logic [2:0] WAIT_ICW2 = 3'b001;
  localparam logic [2:0] WAIT_ICW3 = 3'b010;
  localparam logic [2:0] WAIT_ICW4 = 3'b100;

  // Priority encoder result when no bit is set
  localparam logic [3:0] NO_BIT = 4'd8;

  typedef struct packed {
    action_e    action;
    logic       port;
    logic [7:0] wdata;
    logic [2:0] irq_line;
  } item_t;

  typedef struct packed {
    logic [2:0] init_wait;
    logic       read_isr;
    logic [7:0] irr;
    logic [7:0] imr;
    logic [7:0] isr;
    logic [4:0] base;
    logic       pend;
    logic [2:0] pend_num;
  } state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       request_taken;
    logic       int_pending;
    logic [2:0] pending_line;
    logic [7:0] vector_base;
  } result_t;

  localparam state_t STATE_RESET = '{
    init_wait: 3'b000,
    read_isr:  1'b0,
    irr:       8'h00,
    imr:       IMR_RESET,
    isr:       8'h00,
    base:      5'd0,
    pend:      1'b0,
    pend_num:  3'd0
  };

  // Lowest set bit number, NO_BIT when the byte is zero
  function automatic logic [3:0] lowest_bit(input logic [7:0] v);
    logic [3:0] n;
    n = NO_BIT;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) n = 4'(i);
    end
    return n;
  endfunction

  // Fixed-priority resolver: only ever raises the pending flag
  function automatic state_t resolve(input state_t s);
    state_t     r;
    logic [3:0] req;
    logic [3:0] svc;
    r   = s;
    req = lowest_bit(s.irr & ~s.imr);
    svc = lowest_bit(s.isr);
    if (req < svc) begin
      r.pend     = 1'b1;
      r.pend_num = req[2:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ic8259_engine.sv
// Next-state and result logic for one item of the 8259 core.
// Purely combinational; depends on ic8259_pkg.
`default_nettype none

module ic8259_engine (
  input  ic8259_pkg::state_t  state_i,
  input  ic8259_pkg::item_t   item_i,
  output ic8259_pkg::state_t  state_o,
  output ic8259_pkg::result_t result_o
);
  import ic8259_pkg::*;

  state_t     st;
  logic [3:0] svc;
  logic [7:0] line_bit;
  logic [7:0] ack_bit;
  logic [7:0] rdata;
  logic       taken;

  assign svc      = lowest_bit(state_i.isr);
  assign line_bit = 8'b1 << item_i.irq_line;
  assign ack_bit  = 8'b1 << state_i.pend_num;

  // Apply the action to the controller state
  always_comb begin
    st    = state_i;
    rdata = 8'h00;
    taken = 1'b0;
    case (item_i.action)
      ACT_WRITE: begin
        if (!item_i.port) begin
          if ((item_i.wdata & CMD_ICW1) != 8'h00) begin
            st.init_wait = WAIT_ICW2;
            if ((item_i.wdata & INIT_ICW4_REQ) != 8'h00) begin
              st.init_wait = st.init_wait | WAIT_ICW4;
            end
            if ((item_i.wdata & INIT_SINGLE) == 8'h00) begin
              st.init_wait = st.init_wait | WAIT_ICW3;
            end
          end else if ((item_i.wdata & CMD_OCW3) != 8'h00) begin
            if ((item_i.wdata & OCW3_RR) != 8'h00) begin
              st.read_isr = ((item_i.wdata & RSEL_ISR) != 8'h00);
            end
          end else if ((item_i.wdata & CMD_EOI) != 8'h00) begin
            // non-specific EOI; empty ISR leaves everything alone
            if (svc != NO_BIT) begin
              st.isr = state_i.isr & ~(8'b1 << svc[2:0]);
              st     = resolve(st);
            end
          end
        end else begin
          if ((state_i.init_wait & WAIT_ICW2) != 3'b000) begin
            st.base      = 5'((item_i.wdata & ICW2_BASE) >> 3);
            st.init_wait = state_i.init_wait & ~WAIT_ICW2;
          end else if ((state_i.init_wait & WAIT_ICW3) != 3'b000) begin
            st.init_wait = state_i.init_wait & ~WAIT_ICW3;
          end else if ((state_i.init_wait & WAIT_ICW4) != 3'b000) begin
            st.init_wait = state_i.init_wait & ~WAIT_ICW4;
          end else begin
            st.imr = item_i.wdata;
          end
        end
      end
      ACT_READ: begin
        if (!item_i.port) rdata = state_i.read_isr ? state_i.isr : state_i.irr;
        else              rdata = state_i.imr;
      end
      ACT_RAISE: begin
        // a line already in service is ignored
        if ((state_i.isr & line_bit) == 8'h00) begin
          st.irr = state_i.irr | line_bit;
          st     = resolve(st);
          taken  = 1'b1;
        end
      end
      ACT_ACK: begin
        st.isr  = state_i.isr | ack_bit;
        st.irr  = state_i.irr & ~ack_bit;
        st.pend = 1'b0;
      end
      default: begin
        st = state_i;
      end
    endcase
  end

  assign state_o                = st;
  assign result_o.read_data     = rdata;
  assign result_o.request_taken = taken;
  assign result_o.int_pending   = st.pend;
  assign result_o.pending_line  = st.pend_num;
  assign result_o.vector_base   = {st.base, 3'b000};

endmodule

`default_nettype wire

FILE: sv/interrupt_controller_8259_core.sv
// Simplified 8259 programmable interrupt controller, top level.
// Input register, ic8259_engine, result register; depends on ic8259_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one action per transfer:
//   a port write, a port read, a device raising an IRQ line, or a CPU
//   acknowledge. Output channel (out_valid_o / out_stall_i) returns exactly
//   one result per action: read data, request-taken flag, and the pending
//   flag, pending line and vector base as they stand after the action.
//   Results are registered: out_valid_o rises when the item moves from the
//   input register into the result register.
//   Throughput is one item per cycle while the receiver does not stall: the
//   controller state is read and updated as an item moves from the input
//   register into the result register, so back-to-back items need no bubble.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, after which in_stall_o follows the stall.
//   Reset (rst_ni low, asynchronous) empties both registers and returns the
//   controller to: no init pending, IRR read select, IRR/ISR clear, all lines
//   masked, base vector zero, nothing pending.
`default_nettype none

module interrupt_controller_8259_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic       port_i,
  input  wire logic [7:0] wdata_i,
  input  wire logic [2:0] irq_line_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      read_data_o,
  output logic            request_taken_o,
  output logic            int_pending_o,
  output logic [2:0]      pending_line_o,
  output logic [7:0]      vector_base_o
);
  import ic8259_pkg::*;

  item_t   item_q;
  logic    item_vld_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_q;
  result_t res_d;
  logic    res_vld_q;
  logic    out_adv;
  logic    in_take;

  // Handshake: output register frees when empty or being taken
  assign out_adv    = !res_vld_q || !out_stall_i;
  assign in_stall_o = item_vld_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  ic8259_engine u_engine (
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      state_q    <= STATE_RESET;
    end else begin
      if (out_adv) begin
        res_vld_q <= item_vld_q;
        if (item_vld_q) state_q <= state_d;
      end
      if (in_take) item_vld_q <= 1'b1;
      else if (out_adv) item_vld_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action   <= action_e'(action_i);
      item_q.port     <= port_i;
      item_q.wdata    <= wdata_i;
      item_q.irq_line <= irq_line_i;
    end
    if (out_adv && item_vld_q) res_q <= res_d;
  end

  assign out_valid_o     = res_vld_q;
  assign read_data_o     = res_q.read_data;
  assign request_taken_o = res_q.request_taken;
  assign int_pending_o   = res_q.int_pending;
  assign pending_line_o  = res_q.pending_line;
  assign vector_base_o   = res_q.vector_base;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_vld_q)
    else $error("input stalled with empty input register");

  a_empty_out_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_vld_q |-> !in_stall_o)
    else $error("input stalled while result register is empty");

  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_q && out_adv) |=> out_valid_o)
    else $error("item left input register without producing a result");

endmodule

`default_nettype wire
